>>> rtl/fsi_pkg.sv
// shared types, constants and control store for the format string interpreter
`timescale 1ns / 1ps

package fsi_pkg;

  localparam int INT_BITS_DEF = 32;
  localparam int PTR_BITS_DEF = 64;
  localparam int MAX_RESULTS  = 18;
  localparam int EC_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [3:0] DEC_RADIX = 4'd10;

  // control store addresses
  localparam int UA_W = 4;
  localparam logic [UA_W-1:0] UA_IDLE    = 4'd0;
  localparam logic [UA_W-1:0] UA_ECHO    = 4'd1;
  localparam logic [UA_W-1:0] UA_DEC     = 4'd2;
  localparam logic [UA_W-1:0] UA_SIGN    = 4'd3;
  localparam logic [UA_W-1:0] UA_MINUS   = 4'd4;
  localparam logic [UA_W-1:0] UA_DABBLE  = 4'd5;
  localparam logic [UA_W-1:0] UA_SETUP   = 4'd6;
  localparam logic [UA_W-1:0] UA_SKIP    = 4'd7;
  localparam logic [UA_W-1:0] UA_DIGIT   = 4'd8;
  localparam logic [UA_W-1:0] UA_HEX     = 4'd9;
  localparam logic [UA_W-1:0] UA_PTR0    = 4'd10;
  localparam logic [UA_W-1:0] UA_PTRX    = 4'd11;
  localparam logic [UA_W-1:0] UA_PTRLOAD = 4'd12;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_CHAR,
    EM_LIT,
    EM_DIGIT
  } emit_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD_DEC,
    DP_LOAD_HEX_INT,
    DP_LOAD_HEX_PTR,
    DP_DABBLE,
    DP_SCAN_SETUP,
    DP_SKIP_ZERO,
    DP_SHIFT_DIGIT
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_NOT_NEG,
    C_LOOP,
    C_SKIP,
    C_MORE
  } cond_t;

  typedef struct packed {
    emit_t           emit;
    logic [7:0]      lit;
    dp_op_t          dp;
    cond_t           cond;
    logic [UA_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic   fire;
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic       neg;
    logic       cnt_one;
    logic       top_zero;
    logic [3:0] top_digit;
  } dp_stat_t;

  function automatic uword_t ucode_rom(input logic [UA_W-1:0] addr);
    uword_t uw;
    uw = '{emit: EM_NONE, lit: CH_NUL, dp: DP_NONE, cond: C_JUMP, target: UA_IDLE};
    unique case (addr)
      UA_IDLE:    uw.cond = C_DISPATCH;
      UA_ECHO:    uw.emit = EM_CHAR;
      UA_DEC: begin
        uw.dp   = DP_LOAD_DEC;
        uw.cond = C_NEXT;
      end
      UA_SIGN: begin
        uw.cond   = C_NOT_NEG;
        uw.target = UA_DABBLE;
      end
      UA_MINUS: begin
        uw.emit = EM_LIT;
        uw.lit  = CH_MINUS;
        uw.cond = C_NEXT;
      end
      UA_DABBLE: begin
        uw.dp     = DP_DABBLE;
        uw.cond   = C_LOOP;
        uw.target = UA_DABBLE;
      end
      UA_SETUP: begin
        uw.dp   = DP_SCAN_SETUP;
        uw.cond = C_NEXT;
      end
      UA_SKIP: begin
        uw.dp     = DP_SKIP_ZERO;
        uw.cond   = C_SKIP;
        uw.target = UA_SKIP;
      end
      UA_DIGIT: begin
        uw.emit = EM_DIGIT;
        uw.dp   = DP_SHIFT_DIGIT;
        uw.cond = C_MORE;
      end
      UA_HEX: begin
        uw.dp     = DP_LOAD_HEX_INT;
        uw.target = UA_SKIP;
      end
      UA_PTR0: begin
        uw.emit = EM_LIT;
        uw.lit  = CH_ZERO;
        uw.cond = C_NEXT;
      end
      UA_PTRX: begin
        uw.emit = EM_LIT;
        uw.lit  = CH_X;
        uw.cond = C_NEXT;
      end
      UA_PTRLOAD: begin
        uw.dp     = DP_LOAD_HEX_PTR;
        uw.target = UA_SKIP;
      end
      default: uw.cond = C_JUMP;
    endcase
    return uw;
  endfunction

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    if (d < DEC_RADIX) begin
      return CH_ZERO + {4'b0, d};
    end else begin
      return CH_A + {4'b0, d} - {4'b0, DEC_RADIX};
    end
  endfunction

endpackage

>>> rtl/fsi_in_if.sv
// input channel: format byte and argument
`timescale 1ns / 1ps

interface fsi_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_char;
  logic [63:0] arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

>>> rtl/fsi_out_if.sv
// result channel: one character per transfer
`timescale 1ns / 1ps

interface fsi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

>>> rtl/fsi_digit_unit.sv
// digit datapath: sign/magnitude or hex load, shift-add-3 binary to bcd, zero skip, digit shift-out
`timescale 1ns / 1ps

module fsi_digit_unit #(
  parameter int INT_BITS = fsi_pkg::INT_BITS_DEF,
  parameter int PTR_BITS = fsi_pkg::PTR_BITS_DEF
) (
  input  logic              clk,
  input  fsi_pkg::dp_ctrl_t ctrl,
  input  logic [63:0]       arg_i,
  output fsi_pkg::dp_stat_t stat
);

  localparam int BCD_N   = (INT_BITS * 30103) / 100000 + 1;
  localparam int HEXI_N  = (INT_BITS + 3) / 4;
  localparam int HEXP_N  = (PTR_BITS + 3) / 4;
  localparam int NDIG_A  = (BCD_N > HEXI_N) ? BCD_N : HEXI_N;
  localparam int NDIG    = (NDIG_A > HEXP_N) ? NDIG_A : HEXP_N;
  localparam int DIG_W   = NDIG * 4;
  localparam int CNT_MAX = (INT_BITS > NDIG) ? INT_BITS : NDIG;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  logic [INT_BITS-1:0] mag_r, mag_nxt;
  logic [DIG_W-1:0]    dig_r, dig_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;

  logic [INT_BITS-1:0] int_val;
  logic [DIG_W-1:0]    adj;
  logic [DIG_W-1:0]    dig_shift;
  logic [3:0]          nib;
  logic                cnt_one;
  logic                top_zero;

  assign int_val   = arg_i[INT_BITS-1:0];
  assign dig_shift = {dig_r[DIG_W-5:0], 4'b0};
  assign cnt_one   = (cnt_r == CNT_W'(1));
  assign top_zero  = (dig_r[DIG_W-1 -: 4] == 4'd0);

  // add 3 to every bcd digit of five or more before the next shift
  always_comb begin
    nib = 4'd0;
    adj = '0;
    for (int i = 0; i < NDIG; i++) begin
      nib = dig_r[i*4 +: 4];
      adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_comb begin
    mag_nxt = mag_r;
    dig_nxt = dig_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    if (ctrl.fire) begin
      unique case (ctrl.op)
        fsi_pkg::DP_NONE: ;
        fsi_pkg::DP_LOAD_DEC: begin
          neg_nxt = int_val[INT_BITS-1];
          mag_nxt = int_val[INT_BITS-1] ? (INT_BITS'(0) - int_val) : int_val;
          dig_nxt = '0;
          cnt_nxt = CNT_W'(INT_BITS);
        end
        fsi_pkg::DP_LOAD_HEX_INT: begin
          dig_nxt = DIG_W'(int_val);
          cnt_nxt = CNT_W'(NDIG);
        end
        fsi_pkg::DP_LOAD_HEX_PTR: begin
          dig_nxt = DIG_W'(arg_i[PTR_BITS-1:0]);
          cnt_nxt = CNT_W'(NDIG);
        end
        fsi_pkg::DP_DABBLE: begin
          dig_nxt = {adj[DIG_W-2:0], mag_r[INT_BITS-1]};
          mag_nxt = {mag_r[INT_BITS-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
        end
        fsi_pkg::DP_SCAN_SETUP: cnt_nxt = CNT_W'(NDIG);
        fsi_pkg::DP_SKIP_ZERO: begin
          // the final digit is kept even when zero
          if (top_zero && !cnt_one) begin
            dig_nxt = dig_shift;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        fsi_pkg::DP_SHIFT_DIGIT: begin
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    dig_r <= dig_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.neg       = neg_r;
  assign stat.cnt_one   = cnt_one;
  assign stat.top_zero  = top_zero;
  assign stat.top_digit = dig_r[DIG_W-1 -: 4];

endmodule

>>> rtl/format_string_interpreter_top.sv
// format string interpreter top level: microcoded sequencer and output register
`timescale 1ns / 1ps

// Takes one format byte with its argument per transfer and emits the resulting
// characters, one per output transfer, with last on the final one of each item.
// Plain bytes echo, '%' opens a conversion, and c, d, x, p convert the argument;
// a zero byte or an unknown conversion produces nothing. One item is handled at
// a time: input is taken only while the sequencer sits at its idle step. A plain
// byte or c is echoed, x loads the argument as hex digits, p emits "0x" and
// then loads it the same way, and d emits a minus sign when negative, then runs
// the shift-add-3 conversion that moves one argument bit per cycle. The zero
// skip drops leading zero digits but keeps the last, and the digit shift-out
// emits the rest. NDIG is the digit buffer depth (16 nibbles at the default
// pointer width). Output stalls hold the sequencer on its current emit step.

module format_string_interpreter_top #(
  parameter int INT_BITS = fsi_pkg::INT_BITS_DEF,
  parameter int PTR_BITS = fsi_pkg::PTR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fsi_in_if.sink     in_chan,
  fsi_out_if.source  out_chan
);

  logic [fsi_pkg::UA_W-1:0] pc_r, pc_nxt;
  logic                     esc_r, esc_nxt;
  logic [fsi_pkg::EC_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_char_r, out_char_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [7:0]               ch_r, ch_nxt;
  logic [63:0]              arg_r, arg_nxt;

  fsi_pkg::uword_t          uw;
  fsi_pkg::dp_ctrl_t        dp_ctrl;
  fsi_pkg::dp_stat_t        dp_stat;

  logic                     accept;
  logic                     emit_ok;
  logic                     fire;
  logic                     emit_fire;
  logic [7:0]               emit_char;
  logic                     emit_last;
  logic [fsi_pkg::UA_W-1:0] disp_addr;
  logic                     disp_esc;
  logic [7:0]               disp_ch;

  assign uw             = fsi_pkg::ucode_rom(pc_r);
  assign in_chan.ready  = (pc_r == fsi_pkg::UA_IDLE);
  assign accept         = in_chan.valid && in_chan.ready;
  assign emit_ok        = !out_valid_r || out_chan.ready;
  assign fire           = (uw.cond == fsi_pkg::C_DISPATCH) ? in_chan.valid
                        : ((uw.emit == fsi_pkg::EM_NONE) || emit_ok);
  assign emit_fire      = fire && (uw.emit != fsi_pkg::EM_NONE);
  assign dp_ctrl.fire   = fire;
  assign dp_ctrl.op     = uw.dp;

  // decode the incoming byte against the current mode
  always_comb begin
    disp_addr = fsi_pkg::UA_IDLE;
    disp_esc  = 1'b0;
    disp_ch   = in_chan.fmt_char;
    if (in_chan.fmt_char == fsi_pkg::CH_NUL) begin
      disp_addr = fsi_pkg::UA_IDLE;
    end else if (!esc_r) begin
      if (in_chan.fmt_char == fsi_pkg::CH_PCT) begin
        disp_esc = 1'b1;
      end else begin
        disp_addr = fsi_pkg::UA_ECHO;
      end
    end else begin
      unique case (in_chan.fmt_char)
        fsi_pkg::CH_C: begin
          disp_addr = fsi_pkg::UA_ECHO;
          disp_ch   = in_chan.arg_value[7:0];
        end
        fsi_pkg::CH_D: disp_addr = fsi_pkg::UA_DEC;
        fsi_pkg::CH_X: disp_addr = fsi_pkg::UA_HEX;
        fsi_pkg::CH_P: disp_addr = fsi_pkg::UA_PTR0;
        default:       disp_addr = fsi_pkg::UA_IDLE;
      endcase
    end
  end

  always_comb begin
    emit_char = 8'h00;
    emit_last = 1'b0;
    unique case (uw.emit)
      fsi_pkg::EM_NONE: ;
      fsi_pkg::EM_CHAR: begin
        emit_char = ch_r;
        emit_last = 1'b1;
      end
      fsi_pkg::EM_LIT:  emit_char = uw.lit;
      fsi_pkg::EM_DIGIT: begin
        emit_char = fsi_pkg::digit_ascii(dp_stat.top_digit);
        // final digit, or the character limit is reached
        emit_last = dp_stat.cnt_one ||
                    (emit_cnt_r == fsi_pkg::EC_W'(fsi_pkg::MAX_RESULTS - 1));
      end
      default: ;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (fire) begin
      unique case (uw.cond)
        fsi_pkg::C_NEXT:     pc_nxt = pc_r + 1'b1;
        fsi_pkg::C_JUMP:     pc_nxt = uw.target;
        fsi_pkg::C_DISPATCH: pc_nxt = disp_addr;
        fsi_pkg::C_NOT_NEG:  pc_nxt = dp_stat.neg ? pc_r + 1'b1 : uw.target;
        fsi_pkg::C_LOOP:     pc_nxt = dp_stat.cnt_one ? pc_r + 1'b1 : uw.target;
        fsi_pkg::C_SKIP:     pc_nxt = (dp_stat.top_zero && !dp_stat.cnt_one) ?
                                      uw.target : pc_r + 1'b1;
        fsi_pkg::C_MORE:     pc_nxt = emit_last ? uw.target : pc_r;
        default:             pc_nxt = fsi_pkg::UA_IDLE;
      endcase
    end
  end

  always_comb begin
    esc_nxt      = accept ? disp_esc : esc_r;
    ch_nxt       = accept ? disp_ch : ch_r;
    arg_nxt      = accept ? in_chan.arg_value : arg_r;
    emit_cnt_nxt = accept ? '0 : (emit_fire ? emit_cnt_r + 1'b1 : emit_cnt_r);
    out_valid_nxt = emit_fire ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
    out_char_nxt  = emit_fire ? emit_char : out_char_r;
    out_last_nxt  = emit_fire ? emit_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= fsi_pkg::UA_IDLE;
      esc_r       <= 1'b0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      esc_r       <= esc_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    ch_r       <= ch_nxt;
    arg_r      <= arg_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.last     = out_last_r;

  fsi_digit_unit #(
    .INT_BITS (INT_BITS),
    .PTR_BITS (PTR_BITS)
  ) u_digit_unit (
    .clk   (clk),
    .ctrl  (dp_ctrl),
    .arg_i (arg_r),
    .stat  (dp_stat)
  );

endmodule

>>> rtl/fsi_checker.sv
// port-level assertions for the format string interpreter, bound to the top level
`timescale 1ns / 1ps

module fsi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_fmt_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output changed");

  // an item still in progress never takes new input
  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while item unfinished");

  // a new character comes only from an active sequence
  a_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("character emitted from idle");

  // a terminator byte returns straight to idle
  a_nul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_fmt_char == fsi_pkg::CH_NUL) |=> in_ready)
    else $error("terminator did not return to idle");

endmodule

bind format_string_interpreter_top fsi_checker u_fsi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_fmt_char (in_chan.fmt_char),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_char    (out_chan.out_char),
  .out_last    (out_chan.last)
);
